[sv/merge_sort_engine_defines.svh]
// ----------------------------------------------------------------------------
// Merge sort engine assertion macros
// Shorthand for the clocked, reset-qualified checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define MSE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define MSE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mse_pkg.sv]
// ----------------------------------------------------------------------------
// Merge sort engine package
// Capacity, derived widths and the transaction payload types.
// ----------------------------------------------------------------------------
package mse_pkg;

	// Number of elements one list may hold; later elements are dropped.
	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	// Span arithmetic (lo + 2 * width) needs one more bit than the count.
	localparam int IDX_W     = CNT_W + 1;
	localparam int DATA_W    = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     end_of_list;
		logic                     overflowed;
	} result_t;

endpackage

[sv/merge_sort_engine.sv]
// ----------------------------------------------------------------------------
// Merge sort engine
// Collects a list of signed 32-bit values, sorts it stably in ascending order
// by bottom-up merge passes between two ping-pong memories, then streams it out.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload     handshake
//   item      in          item_t      item_valid / item_ready
//   result    out         result_t    result_valid / result_ready
//
// Loading stores each accepted transaction; the one marked is_last starts ceil(log2(n))
// merge passes. Each pair of runs first reads the head of its left run, then of its
// right run, then merges one element per cycle, bound by the single read port of the
// source memory. Each accepted result is followed by a capture of the next element's
// read data before that element is offered as the next result.
// Reset clears counters and sequencer only; item stalls until the last result is taken.

module merge_sort_engine
	import mse_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Sequencer states.
	localparam logic [2:0] ST_LOAD    = 3'd0; // collecting elements
	localparam logic [2:0] ST_PRIME_A = 3'd1; // read head of the left run
	localparam logic [2:0] ST_PRIME_B = 3'd2; // read head of the right run
	localparam logic [2:0] ST_MERGE   = 3'd3; // one element per cycle
	localparam logic [2:0] ST_OUT_RD  = 3'd4; // read first sorted element
	localparam logic [2:0] ST_OUT_CAP = 3'd5; // capture read data into output
	localparam logic [2:0] ST_OUT_HLD = 3'd6; // wait for the result handshake

	// Which run head arrives in this cycle's read data.
	localparam logic FWD_A = 1'b0;
	localparam logic FWD_B = 1'b1;

	logic [2:0] state_q;

	// List bookkeeping.
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] n_q;

	// Merge pass bookkeeping. All run bounds use IDX_W bits.
	logic [IDX_W-1:0] width_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] mid_q;
	logic [IDX_W-1:0] hi_q;
	logic [IDX_W-1:0] a_idx_q;
	logic [IDX_W-1:0] b_idx_q;
	logic [IDX_W-1:0] k_q;
	logic             src_q;  // 0: mem0 is the source of this pass
	logic             fwd_q;

	logic [CNT_W-1:0] out_idx_q;

	logic signed [DATA_W-1:0] head_a_q;
	logic signed [DATA_W-1:0] head_b_q;
	logic                     result_valid_q;
	result_t                  result_q;

	// Ping-pong element memories with registered read data.
	logic [DATA_W-1:0] mem0 [MAX_ITEMS];
	logic [DATA_W-1:0] mem1 [MAX_ITEMS];
	logic [DATA_W-1:0] rdata0_q;
	logic [DATA_W-1:0] rdata1_q;

	logic                     item_accept;
	logic                     result_accept;
	logic                     room;
	logic [CNT_W-1:0]         count_nxt;
	logic [IDX_W-1:0]         n_ext;
	logic [IDX_W-1:0]         lo_plus_w;
	logic [IDX_W-1:0]         lo_plus_2w;
	logic [IDX_W-1:0]         mid_c;
	logic [IDX_W-1:0]         hi_c;
	logic [IDX_W-1:0]         width_dbl;
	logic [IDX_W-1:0]         k_inc;
	logic signed [DATA_W-1:0] src_rdata;
	logic signed [DATA_W-1:0] eff_a;
	logic signed [DATA_W-1:0] eff_b;
	logic                     a_avail;
	logic                     b_avail;
	logic                     take_b;
	logic signed [DATA_W-1:0] merge_wdata;
	logic                     pair_done;
	logic                     pass_done;
	logic                     sort_done;
	logic [IDX_W-1:0]         rd_idx;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     wr0_en;
	logic                     wr1_en;
	logic [ADDR_W-1:0]        wr0_addr;
	logic [DATA_W-1:0]        wr0_data;

	assign item_ready    = (state_q == ST_LOAD);
	assign item_accept   = item_valid & item_ready;
	assign result_valid  = result_valid_q;
	assign result        = result_q;
	assign result_accept = result_valid_q & result_ready;

	// A full store drops the element and marks the list as overflowed.
	assign room      = (count_q < CNT_W'(MAX_ITEMS));
	assign count_nxt = count_q + CNT_W'(room);

	// Bounds of the next pair of runs, clipped to the list length. A tail
	// with no right run becomes a merge against an empty run, i.e. a copy.
	assign n_ext      = IDX_W'(n_q);
	assign lo_plus_w  = lo_q + width_q;
	assign lo_plus_2w = lo_q + (width_q << 1);
	assign mid_c      = (lo_plus_w  < n_ext) ? lo_plus_w  : n_ext;
	assign hi_c       = (lo_plus_2w < n_ext) ? lo_plus_2w : n_ext;
	assign width_dbl  = width_q << 1;

	assign src_rdata = src_q ? rdata1_q : rdata0_q;

	// The head refilled in the previous cycle comes straight from the read data.
	assign eff_a = (fwd_q == FWD_A) ? src_rdata : head_a_q;
	assign eff_b = (fwd_q == FWD_B) ? src_rdata : head_b_q;

	assign a_avail = (a_idx_q < mid_q);
	assign b_avail = (b_idx_q < hi_q);
	// Ties go to the left run, which keeps the sort stable.
	assign take_b      = b_avail & (~a_avail | (eff_a > eff_b));
	assign merge_wdata = take_b ? eff_b : eff_a;

	assign k_inc     = k_q + IDX_W'(1);
	assign pair_done = (k_inc == hi_q);
	assign pass_done = (hi_q >= n_ext);
	assign sort_done = (width_dbl >= n_ext);

	always_comb begin
		case (state_q)
			ST_PRIME_A: rd_idx = lo_q;
			ST_PRIME_B: rd_idx = mid_q;
			ST_MERGE:   rd_idx = take_b ? (b_idx_q + IDX_W'(1)) : (a_idx_q + IDX_W'(1));
			ST_OUT_RD:  rd_idx = IDX_W'(out_idx_q);
			ST_OUT_HLD: rd_idx = IDX_W'(out_idx_q) + IDX_W'(1);
			default:    rd_idx = '0;
		endcase
	end

	// Reads past the end of a run land on data that is never used.
	assign rd_addr = rd_idx[ADDR_W-1:0];

	// mem0 takes the incoming list and the output of even-numbered passes (the first pass writes mem1).
	assign wr0_en   = (item_accept & room) | ((state_q == ST_MERGE) & src_q);
	assign wr1_en   = (state_q == ST_MERGE) & ~src_q;
	assign wr0_addr = (state_q == ST_LOAD) ? count_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
	assign wr0_data = (state_q == ST_LOAD) ? item.value : merge_wdata;

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			mem0[wr0_addr] <= wr0_data;
		end
		if (wr1_en) begin
			mem1[k_q[ADDR_W-1:0]] <= merge_wdata;
		end
		rdata0_q <= mem0[rd_addr];
		rdata1_q <= mem1[rd_addr];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_PRIME_B) begin
			head_a_q <= src_rdata;
		end
		if (state_q == ST_MERGE) begin
			head_a_q <= eff_a;
			head_b_q <= eff_b;
		end
		if (state_q == ST_OUT_CAP) begin
			result_q.sorted_value <= src_rdata;
			result_q.end_of_list  <= (out_idx_q + CNT_W'(1) == n_q);
			result_q.overflowed   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			n_q            <= '0;
			width_q        <= '0;
			lo_q           <= '0;
			mid_q          <= '0;
			hi_q           <= '0;
			a_idx_q        <= '0;
			b_idx_q        <= '0;
			k_q            <= '0;
			src_q          <= 1'b0;
			fwd_q          <= FWD_A;
			out_idx_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_accept) begin
						count_q <= count_nxt;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (item.is_last) begin
							// The list always holds at least one element here.
							n_q       <= count_nxt;
							width_q   <= IDX_W'(1);
							lo_q      <= '0;
							src_q     <= 1'b0;
							out_idx_q <= '0;
							if (count_nxt > CNT_W'(1)) begin
								state_q <= ST_PRIME_A;
							end else begin
								state_q <= ST_OUT_RD;
							end
						end
					end
				end
				ST_PRIME_A: begin
					mid_q   <= mid_c;
					hi_q    <= hi_c;
					a_idx_q <= lo_q;
					b_idx_q <= mid_c;
					k_q     <= lo_q;
					state_q <= ST_PRIME_B;
				end
				ST_PRIME_B: begin
					fwd_q   <= FWD_B;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					k_q   <= k_inc;
					fwd_q <= take_b ? FWD_B : FWD_A;
					if (take_b) begin
						b_idx_q <= b_idx_q + IDX_W'(1);
					end else begin
						a_idx_q <= a_idx_q + IDX_W'(1);
					end
					if (pair_done) begin
						if (pass_done) begin
							// Destination becomes the source of the next pass.
							width_q <= width_dbl;
							lo_q    <= '0;
							src_q   <= ~src_q;
							state_q <= sort_done ? ST_OUT_RD : ST_PRIME_A;
						end else begin
							lo_q    <= hi_q;
							state_q <= ST_PRIME_A;
						end
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_CAP;
				end
				ST_OUT_CAP: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_OUT_HLD;
				end
				ST_OUT_HLD: begin
					if (result_accept) begin
						result_valid_q <= 1'b0;
						if (result_q.end_of_list) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							out_idx_q <= out_idx_q + CNT_W'(1);
							state_q   <= ST_OUT_CAP;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[sv/mse_checker.sv]
// ----------------------------------------------------------------------------
// Merge sort engine checker
// Port-level checks of the engine's handshakes and list framing.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_defines.svh"

module mse_checker
	import mse_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result keeps its valid and its payload.
	`MSE_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// The engine never takes a new element while a result is on offer.
	`MSE_ASSERT_IMP(a_no_overlap, result_valid, !item_ready, "item_ready high while a result is pending")

	// Once the final element arrives, input is closed while the list sorts.
	`MSE_ASSERT_NXT(a_close_on_last, item_valid && item_ready && item.is_last, !item_ready && !result_valid, "input not closed after the last element")

	// Accepting the end of a list leaves no result behind it.
	`MSE_ASSERT_NXT(a_end_clears, result_valid && result_ready && result.end_of_list, !result_valid && item_ready, "engine not idle after the end of a list")

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

[verif/merge_sort_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine testbench
// Streams lists of signed values into the engine and checks every sorted
// result transaction against a behavioral sort kept alongside the stimulus.
// ----------------------------------------------------------------------------
module merge_sort_engine_test;
	import mse_pkg::*;

	// The run is ended by the watchdog if it gets this far. A correct run finishes
	// before this limit even with every full list sorted at its worst case and
	// every result stalled by the receiver.
	localparam int CYCLE_LIMIT   = 200000;
	// Total number of items to queue, directed lists included. Random lists
	// are added until this count is reached.
	localparam int ITEM_TARGET   = 330;
	// The receiver stops taking results for this long, once, after this many
	// results have been checked. The sender keeps offering items meanwhile.
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 40;
	// Quiet cycles after the last result before the verdict.
	localparam int SETTLE_CYCLES = 300;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	// One queued input transaction. When wait_drain is set the sender holds
	// this item back until every predicted result has been checked.
	typedef struct {
		item_t payload;
		bit    wait_drain;
	} stim_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	stim_t                    pending[$];
	result_t                  sorted_due[$];
	logic signed [DATA_W-1:0] open_list[$];
	bit                       open_dropped;

	int items_taken;
	int predicted_total;
	int checked_total;
	// Copy of checked_total updated with a nonblocking assignment, so that the
	// sender reads a value that does not depend on process order at the edge.
	int checked_seen;
	int mismatches;
	int cycle_count;
	int hold_left;
	bit hold_done;

	merge_sort_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Takes one accepted item into the open list. Once the store is full, the
	// item is dropped and the list is marked as overflowed; this holds for the
	// final item too, which still closes the list. On the final item the kept
	// elements are sorted and one expected result per element is queued.
	task automatic predict_sorted_run(input item_t it);
		logic signed [DATA_W-1:0] run[$];
		logic signed [DATA_W-1:0] v;
		result_t                  r;
		int                       j;
		if (open_list.size() < MAX_ITEMS) begin
			open_list.insert(open_list.size(), it.value);
		end else begin
			open_dropped = 1'b1;
		end
		if (it.is_last) begin
			run = open_list;
			// Insertion sort. Only a strictly greater element moves up, so
			// equal values keep their arrival order, as a stable sort must.
			for (int i = 1; i < run.size(); i++) begin
				v = run[i];
				j = i;
				while (j > 0 && run[j-1] > v) begin
					run[j] = run[j-1];
					j--;
				end
				run[j] = v;
			end
			foreach (run[k]) begin
				r.sorted_value = run[k];
				r.end_of_list  = (k == run.size() - 1);
				r.overflowed   = open_dropped;
				sorted_due.insert(sorted_due.size(), r);
				predicted_total++;
			end
			open_list.delete();
			open_dropped = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mix of the range extremes, a narrow band that produces many ties, and
	// full-width random values that exercise every bit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic add_item(input logic signed [DATA_W-1:0] v, input bit last,
			input bit drain);
		stim_t s;
		s.payload.value   = v;
		s.payload.is_last = last;
		s.wait_drain      = drain;
		pending.insert(pending.size(), s);
	endtask

	task automatic add_list(input int len, input bit drain);
		for (int i = 0; i < len; i++) begin
			add_item(pick_value(), i == len - 1, drain && i == 0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Item driver
	// ------------------------------------------------------------------------

	// The sender idles about a quarter of the time, except in a calm window
	// where it offers an item on every free cycle. A held item stays on the
	// bus unchanged until it is taken.
	always @(posedge clk) begin : drive_items
		bit    offer;
		stim_t next_s;
		offer = 1'b0;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				predict_sorted_run(item);
				items_taken++;
			end
			if (!item_valid || item_ready) begin
				if (pending.size() != 0
						&& !(pending[0].wait_drain && checked_seen != predicted_total)
						&& ((items_taken >= 230 && items_taken < 300)
							|| $urandom_range(0, 99) >= 25)) begin
					offer = 1'b1;
				end
				if (offer) begin
					next_s = pending.pop_front();
					item_valid <= 1'b1;
					item       <= next_s.payload;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------

	// Every accepted result transaction is compared field by field with the
	// oldest outstanding prediction. Ready drops at random about a quarter of
	// the time, never in a calm window, and once for a long hold-off during
	// which the engine backs up and stops taking items.
	always @(posedge clk) begin : check_results
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (sorted_due.size() == 0) begin
					$error("unexpected result transaction: sorted_value %0d",
						result.sorted_value);
					mismatches++;
				end else begin
					want = sorted_due.pop_front();
					if (result.sorted_value !== want.sorted_value) begin
						$error("sorted_value: expected %0d, got %0d",
							want.sorted_value, result.sorted_value);
						mismatches++;
					end
					if (result.end_of_list !== want.end_of_list) begin
						$error("end_of_list: expected %0b, got %0b",
							want.end_of_list, result.end_of_list);
						mismatches++;
					end
					if (result.overflowed !== want.overflowed) begin
						$error("overflowed: expected %0b, got %0b",
							want.overflowed, result.overflowed);
						mismatches++;
					end
					checked_total++;
					checked_seen <= checked_total;
				end
			end
			if (!hold_done && checked_total >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= (checked_total >= 220 && checked_total < 290)
					|| $urandom_range(0, 99) >= 25;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Run control
	// ------------------------------------------------------------------------

	initial begin : run_control
		int random_count;
		int len;

		// Directed lists: single elements, a reversed pair, the range extremes,
		// ties, and lists already in order and in reverse order.
		add_item('0, 1'b1, 1'b0);
		add_item(VAL_MIN, 1'b1, 1'b0);
		add_item(VAL_MAX, 1'b0, 1'b0);
		add_item(VAL_MIN, 1'b1, 1'b0);
		add_item(VAL_MAX, 1'b0, 1'b0);
		add_item(VAL_MIN, 1'b0, 1'b0);
		add_item(-1, 1'b0, 1'b0);
		add_item('0, 1'b0, 1'b0);
		add_item(1, 1'b1, 1'b0);
		add_item(3, 1'b0, 1'b0);
		add_item(-3, 1'b0, 1'b0);
		add_item(3, 1'b0, 1'b0);
		add_item(-3, 1'b1, 1'b0);
		for (int i = -2; i <= 3; i++) begin
			add_item(i, i == 3, 1'b0);
		end
		for (int i = 4; i >= 0; i--) begin
			add_item(i, i == 0, 1'b0);
		end

		// A list that exactly fills the store, entered only once the directed
		// results have all come back. Then a list that overflows by three, and
		// one where only the final item is dropped but still closes the list.
		add_list(MAX_ITEMS, 1'b1);
		add_list(MAX_ITEMS + 3, 1'b0);
		add_list(MAX_ITEMS + 1, 1'b0);
		random_count = pending.size();

		// Mostly short lists to keep sort time down, now and then a long one
		// that may overflow, and occasionally a pause until the engine drains.
		while (random_count < ITEM_TARGET) begin
			if ($urandom_range(0, 11) == 0) begin
				len = $urandom_range(17, MAX_ITEMS + 6);
			end else begin
				len = $urandom_range(1, 16);
			end
			add_list(len, $urandom_range(0, 9) == 0);
			random_count += len;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled on the falling edge, where nothing is changing.
		do begin
			@(negedge clk);
		end while (pending.size() != 0 || item_valid || sorted_due.size() != 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// A hung handshake or a missing result ends up here.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule
